// File: rtl/core/mmoe_pkg.sv
// ----------------------------------------------------------------------------
// mmoe_pkg
// Shared types and constants of the median / MAD outlier estimator.
// ----------------------------------------------------------------------------
package mmoe_pkg;

	// value and register widths
	localparam int VAL_W   = 24;
	localparam int LIM_W   = 23;
	localparam int K_W     = 8;
	localparam int RHS_W   = K_W + VAL_W;
	localparam int CFG_IW  = 2;

	// widths of the command index and the count status, sized for the full
	// range of the set size
	localparam int CNT_W   = 6;
	localparam int M_W     = 5;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_MAX_GROUND = 2'd0;
	localparam logic [CFG_IW-1:0] REG_MAD_MULT   = 2'd1;

	localparam logic [LIM_W-1:0] MAX_GROUND_RST = 23'd25600;
	localparam logic [K_W-1:0]   MAD_MULT_RST   = 8'd48;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_STORE,
		OP_OPEN,
		OP_LOAD_S,
		OP_LOAD_D,
		OP_SORT,
		OP_PICK,
		OP_MED,
		OP_MAD,
		OP_MUL,
		OP_SUM,
		OP_DIVI,
		OP_DIV,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [M_W-1:0] m;
		logic           out_full;
	} stat_t;

endpackage

// File: rtl/core/mmoe_dp.sv
// ----------------------------------------------------------------------------
// mmoe_dp
// Datapath: survivor store, sort network, median pick, inlier sum, divider.
// ----------------------------------------------------------------------------
module mmoe_dp #(
	parameter int STORED_MAX = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmoe_pkg::cmd_t                cmd,
	output mmoe_pkg::stat_t               stat,
	input  logic [mmoe_pkg::VAL_W-1:0]    reading,
	input  logic                          finite,
	input  logic                          cfg_we,
	input  logic [mmoe_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [mmoe_pkg::LIM_W-1:0]    cfg_data,
	output logic [mmoe_pkg::VAL_W-1:0]    est,
	output logic                          est_ok,
	output logic                          out_valid,
	input  logic                          out_ready
);
	import mmoe_pkg::*;

	localparam int SLOTS = STORED_MAX + 1;
	localparam int IW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int SW    = LIM_W + CW;

	logic [VAL_W-1:0] surv_q [SLOTS];
	logic [VAL_W-1:0] dev_q  [SLOTS];
	logic [VAL_W-1:0] work_q [SLOTS];
	logic [CW-1:0]    cnt_q, seen_q, m_q, inl_q;
	logic [VAL_W-1:0] cur_q, lo_q, hi_q, med_q, mad_q;
	logic             cur_ok_q;
	logic [RHS_W-1:0] rhs_q;
	logic [SW-1:0]    sum_q, quo_q;
	logic [CW:0]      rem_q;
	logic [LIM_W-1:0] max_q;
	logic [K_W-1:0]   k_q;
	logic [VAL_W-1:0] est_q;
	logic             ok_q, valid_q;

	logic             surv_ok;
	logic [CW-1:0]    k_idx, half;
	logic [VAL_W:0]   pair_sum;
	logic [VAL_W-1:0] mid_val;
	logic             inlier;
	logic [CW:0]      r2;
	logic [VAL_W-1:0] est_div;
	logic [VAL_W:0]   avg_sum;

	assign surv_ok  = finite && !reading[VAL_W-1] &&
		(reading[LIM_W-1:0] <= max_q);
	assign k_idx    = cmd.idx[CW-1:0];
	assign half     = m_q >> 1;
	assign pair_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_val  = m_q[0] ? hi_q : pair_sum[VAL_W:1];
	assign inlier   = (mad_q == '0) ||
		(RHS_W'({dev_q[0], 4'b0000}) <= rhs_q);
	assign r2       = {rem_q[CW-1:0], quo_q[SW-1]};
	assign est_div  = (inl_q == '0) ? med_q : quo_q[VAL_W-1:0];
	assign avg_sum  = {1'b0, est_div} + {1'b0, cur_q};

	assign stat.m        = M_W'(m_q);
	assign stat.out_full = valid_q;
	assign est           = est_q;
	assign est_ok        = ok_q;
	assign out_valid     = valid_q;

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			seen_q  <= '0;
			max_q   <= MAX_GROUND_RST;
			k_q     <= MAD_MULT_RST;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_GROUND: max_q <= cfg_data;
					REG_MAD_MULT:   k_q   <= cfg_data[K_W-1:0];
					default:        ;
				endcase
			end
			if (cmd.op == OP_FIN)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			case (cmd.op)
				OP_STORE: begin
					if (seen_q < CW'(STORED_MAX)) begin
						seen_q <= seen_q + 1'b1;
						if (surv_ok && cnt_q < CW'(STORED_MAX))
							cnt_q <= cnt_q + 1'b1;
					end
				end
				OP_OPEN: begin
					cnt_q  <= '0;
					seen_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_STORE: begin
				if (seen_q < CW'(STORED_MAX) && surv_ok && cnt_q < CW'(STORED_MAX))
					surv_q[cnt_q[IW-1:0]] <= reading;
			end
			OP_OPEN: begin
				cur_q    <= reading;
				cur_ok_q <= surv_ok;
				if (surv_ok) begin
					surv_q[cnt_q[IW-1:0]] <= reading;
					m_q <= cnt_q + 1'b1;
				end else begin
					m_q <= cnt_q;
				end
			end
			OP_LOAD_S: begin
				for (int i = 0; i < SLOTS; i++)
					work_q[i] <= (CW'(i) < m_q) ? surv_q[i] : '1;
			end
			OP_LOAD_D: begin
				for (int i = 0; i < SLOTS; i++) begin
					dev_q[i] <= (surv_q[i] >= med_q) ? surv_q[i] - med_q
						: med_q - surv_q[i];
					work_q[i] <= (CW'(i) < m_q) ? ((surv_q[i] >= med_q) ?
						surv_q[i] - med_q : med_q - surv_q[i]) : '1;
				end
			end
			OP_SORT: begin
				// odd-even transposition pass, parity from the pass count
				for (int i = 0; i + 1 < SLOTS; i++) begin
					if ((i % 2) == int'(cmd.idx[0]) && work_q[i] > work_q[i+1]) begin
						work_q[i]   <= work_q[i+1];
						work_q[i+1] <= work_q[i];
					end
				end
			end
			OP_PICK: begin
				if (k_idx == half)
					hi_q <= work_q[0];
				if (k_idx == half - 1'b1)
					lo_q <= work_q[0];
				for (int i = 0; i + 1 < SLOTS; i++)
					work_q[i] <= work_q[i+1];
				work_q[SLOTS-1] <= '1;
			end
			OP_MED: med_q <= mid_val;
			OP_MAD: mad_q <= mid_val;
			OP_MUL: begin
				rhs_q <= RHS_W'(k_q) * RHS_W'(mad_q);
				sum_q <= '0;
				inl_q <= '0;
			end
			OP_SUM: begin
				if (k_idx < m_q && inlier) begin
					sum_q <= sum_q + SW'(surv_q[0]);
					inl_q <= inl_q + 1'b1;
				end
				for (int i = 0; i + 1 < SLOTS; i++) begin
					surv_q[i] <= surv_q[i+1];
					dev_q[i]  <= dev_q[i+1];
				end
			end
			OP_DIVI: begin
				quo_q <= sum_q;
				rem_q <= '0;
			end
			OP_DIV: begin
				// restoring division, one quotient bit a cycle
				if (r2 >= {1'b0, inl_q}) begin
					rem_q <= r2 - {1'b0, inl_q};
					quo_q <= {quo_q[SW-2:0], 1'b1};
				end else begin
					rem_q <= r2;
					quo_q <= {quo_q[SW-2:0], 1'b0};
				end
			end
			OP_FIN: begin
				if (m_q == '0) begin
					est_q <= '0;
					ok_q  <= 1'b0;
				end else begin
					est_q <= cur_ok_q ? avg_sum[VAL_W:1] : est_div;
					ok_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/mmoe_ctrl.sv
// ----------------------------------------------------------------------------
// mmoe_ctrl
// Sequencer for collection, two sort/pick rounds, inlier sum and division.
// ----------------------------------------------------------------------------
module mmoe_ctrl #(
	parameter int STORED_MAX = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	input  logic            out_ready,
	input  mmoe_pkg::stat_t stat,
	output mmoe_pkg::cmd_t  cmd
);
	import mmoe_pkg::*;

	localparam int SLOTS = STORED_MAX + 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int SW    = LIM_W + CW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_LOAD, ST_SORT, ST_PICK, ST_MED,
		ST_MUL, ST_SUM, ST_DIVI, ST_DIV, ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             phase_q;
	logic             fin_go;

	assign in_ready = (state_q == ST_IDLE);
	assign fin_go   = !stat.out_full || out_ready;

	always_comb begin
		cmd.idx = cnt_q;
		case (state_q)
			ST_IDLE: cmd.op = !in_valid ? OP_NOP : (in_last ? OP_OPEN : OP_STORE);
			ST_LOAD: cmd.op = phase_q ? OP_LOAD_D : OP_LOAD_S;
			ST_SORT: cmd.op = OP_SORT;
			ST_PICK: cmd.op = OP_PICK;
			ST_MED:  cmd.op = phase_q ? OP_MAD : OP_MED;
			ST_MUL:  cmd.op = OP_MUL;
			ST_SUM:  cmd.op = OP_SUM;
			ST_DIVI: cmd.op = OP_DIVI;
			ST_DIV:  cmd.op = OP_DIV;
			ST_FIN:  cmd.op = fin_go ? OP_FIN : OP_NOP;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_last)
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					phase_q <= 1'b0;
					state_q <= (stat.m == '0) ? ST_FIN : ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_SORT;
				end
				ST_SORT: begin
					if (cnt_q == CNT_W'(SLOTS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_PICK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PICK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(stat.m >> 1))
						state_q <= ST_MED;
				end
				ST_MED: begin
					phase_q <= 1'b1;
					state_q <= phase_q ? ST_MUL : ST_LOAD;
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SLOTS - 1))
						state_q <= ST_DIVI;
				end
				ST_DIVI: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SW - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/median_mad_outlier_estimator.sv
// ----------------------------------------------------------------------------
// median_mad_outlier_estimator
// Robust ground estimate from a set of distance readings by median / MAD.
// ----------------------------------------------------------------------------
// usage
//   s_* carries readings: tdata the Q15.8 reading, tuser the finite flag,
//   tlast marks the current reading that closes a set
//   stored readings are taken while idle; a set holds at most STORED_MAX of them
//   the current reading starts the computation; s_tready stays low until done
//   m_* carries one result per set: tdata the estimate, tuser the ok flag
//   from the current reading to m_tvalid the block runs two sort rounds,
//   two median picks, the inlier scan and the bit-serial divider
//   a set with no survivors skips straight to the result
//   the result sits in an output register; if m_tready is low the next set
//   still collects stored readings, and the next result waits for the slot
//   cfg_* writes a register at any time the block is idle; cfg_ready is high
//   reset clears the counts, the output valid and loads register defaults
// ----------------------------------------------------------------------------
module median_mad_outlier_estimator #(
	parameter int STORED_MAX = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mmoe_pkg::VAL_W-1:0]  s_tdata,   // [23:0] reading
	input  logic                        s_tuser,   // [0] reading_finite
	input  logic                        s_tlast,   // is_current
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mmoe_pkg::VAL_W-1:0]  m_tdata,   // [23:0] estimate
	output logic                        m_tuser,   // [0] estimate_ok
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mmoe_pkg::CFG_IW-1:0] cfg_index,
	input  logic [mmoe_pkg::LIM_W-1:0]  cfg_data
);
	import mmoe_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// register writes never stall
	assign cfg_ready = 1'b1;

	mmoe_ctrl #(
		.STORED_MAX(STORED_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.out_ready(m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mmoe_dp #(
		.STORED_MAX(STORED_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.reading  (s_tdata),
		.finite   (s_tuser),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.est      (m_tdata),
		.est_ok   (m_tuser),
		.out_valid(m_tvalid),
		.out_ready(m_tready)
	);

endmodule
